>>> rtl/vqsr_pkg.sv
// shared constants, codes and command/status types of the value queue
package vqsr_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // stream widths
  localparam int S_TDATA_W    = VALUE_W;
  localparam int S_TUSER_W    = OP_W;
  localparam int OUT_FIELDS_W = VALUE_W + STATUS_W + 1 + COUNT_W;
  localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W        = M_TDATA_W - OUT_FIELDS_W;

  // bit positions of the result fields in m_axis_tdata
  localparam int RES_LSB    = 0;
  localparam int STATUS_LSB = VALUE_W;
  localparam int FOUND_LSB  = STATUS_LSB + STATUS_W;
  localparam int COUNT_LSB  = FOUND_LSB + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_HAS = 2'd2,
    OP_DEL = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_MISSING = 3'd2,
    ST_FULL    = 3'd3,
    ST_DUP     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TAILCMP,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  // read address select of the entry memory
  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX1,
    RA_IDX2,
    RA_TAIL
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    idx_inc;
    logic    wr_tail;
    logic    wr_shift;
    logic    cnt_dec;
    logic    set_status;
    status_e status;
    logic    set_found;
    logic    take_res;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic more1;
    logic more2;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/vqsr_datapath.sv
// entry memory, counters, comparator and output register of the value queue
module vqsr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [vqsr_pkg::OP_W-1:0]      op_i,
  input  logic [vqsr_pkg::VALUE_W-1:0]   value_i,
  input  vqsr_pkg::dp_cmd_t              cmd_i,
  output vqsr_pkg::dp_stat_t             stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vqsr_pkg::M_TDATA_W-1:0] out_data_o
);
  import vqsr_pkg::*;

  logic [VALUE_W-1:0]   mem [DEPTH];
  logic [VALUE_W-1:0]   rd_data_q;
  op_e                  op_q;
  logic [VALUE_W-1:0]   val_q;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [VALUE_W-1:0]   res_q;
  status_e              status_q;
  logic                 found_q;
  logic                 out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [CNT_W:0]       idx1, idx2;
  logic [CNT_W-1:0]     tail;
  logic [IDX_W-1:0]     rd_addr;

  // neighbour indexes, one bit wider so they never wrap
  assign idx1 = {1'b0, idx_q} + (CNT_W + 1)'(1);
  assign idx2 = {1'b0, idx_q} + (CNT_W + 1)'(2);
  assign tail = count_q - CNT_W'(1);

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RA_IDX:  rd_addr = idx_q[IDX_W-1:0];
      RA_IDX1: rd_addr = idx1[IDX_W-1:0];
      RA_IDX2: rd_addr = idx2[IDX_W-1:0];
      RA_TAIL: rd_addr = tail[IDX_W-1:0];
      default: rd_addr = idx_q[IDX_W-1:0];
    endcase
  end

  // entry memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tail) begin
      mem[count_q[IDX_W-1:0]] <= val_q;
    end else if (cmd_i.wr_shift) begin
      mem[idx_q[IDX_W-1:0]] <= rd_data_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // request latch and result build-up
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_e'(op_i);
      val_q    <= value_i;
      res_q    <= '0;
      status_q <= ST_OK;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
      if (cmd_i.take_res) begin
        res_q <= rd_data_q;
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{PAD_W{1'b0}}, COUNT_W'(count_q), found_q, status_q, res_q};
    end
  end

  // index and fill count
  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx1[CNT_W-1:0];
    end
    if (cmd_i.wr_tail) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // status towards the controller
  assign stat_o.op       = op_q;
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.cnt_full = (count_q == CNT_W'(DEPTH));
  assign stat_o.match    = (rd_data_q == val_q);
  assign stat_o.more1    = (idx1 < {1'b0, count_q});
  assign stat_o.more2    = (idx2 < {1'b0, count_q});
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/vqsr_ctrl.sv
// sequencing state machine of the value queue
module vqsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vqsr_pkg::dp_stat_t stat_i,
  output vqsr_pkg::dp_cmd_t  cmd_o
);
  import vqsr_pkg::*;

  state_e state_q, state_d;
  logic   hit;

  // dequeue takes the head without a compare
  assign hit = stat_i.match || (stat_i.op == OP_DEQ);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.cnt_zero) state_d = S_FINISH;
        else if (stat_i.op == OP_ENQ) state_d = S_TAILCMP;
        else state_d = S_SCAN;
      end
      S_TAILCMP: begin
        state_d = S_FINISH;
      end
      S_SCAN: begin
        if (hit) begin
          if (stat_i.op != OP_HAS && stat_i.more1) state_d = S_SHIFT;
          else state_d = S_FINISH;
        end else if (!stat_i.more1) begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (!stat_i.more2) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RA_IDX;
    cmd_o.status = ST_OK;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_DECODE: begin
        if (stat_i.cnt_zero) begin
          case (stat_i.op)
            OP_ENQ: cmd_o.wr_tail = 1'b1;
            OP_HAS: begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_MISSING;
            end
            default: begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
            end
          endcase
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = (stat_i.op == OP_ENQ) ? RA_TAIL : RA_IDX;
        end
      end
      S_TAILCMP: begin
        if (stat_i.match) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DUP;
        end else if (stat_i.cnt_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
        end else begin
          cmd_o.wr_tail = 1'b1;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (stat_i.op == OP_HAS) begin
            cmd_o.set_found = 1'b1;
          end else begin
            cmd_o.take_res = 1'b1;
            if (stat_i.more1) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_IDX1;
            end else begin
              cmd_o.cnt_dec = 1'b1;
            end
          end
        end else if (stat_i.more1) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = RA_IDX1;
          cmd_o.idx_inc = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_MISSING;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        if (stat_i.more2) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDX2;
        end else begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        cmd_o.accept = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/value_queue_search_remove.sv
// top level of the bounded value queue with search and remove
// Bounded FIFO of DEPTH signed 32-bit values held in a single-port-style
// entry memory (one write and one registered read per cycle). Each request
// carries an operation in s_axis_tuser (0 enqueue, 1 dequeue head, 2 contains
// test, 3 remove first matching value) and a value in s_axis_tdata, and gives
// exactly one result. One request is worked at a time. The search and the
// gap-closing shift walk the entry memory one entry per cycle, so a request
// takes longer the more entries are stored; a request on an empty queue ends
// straight after decode. The result sits in an output register, so the next
// request is taken while it waits.
module value_queue_search_remove (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] item_value
  input  logic [vqsr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [vqsr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] result_value, [34:32] status, [35] found, [40:36] entry_count, [47:41] zero
  output logic [vqsr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import vqsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  vqsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and compare
  vqsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> rtl/vqsr_checker.sv
// port-level checks of the value queue, bound to the top level
module vqsr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [vqsr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [vqsr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [vqsr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import vqsr_pkg::*;

  logic [VALUE_W-1:0]  res_f;
  logic [STATUS_W-1:0] status_f;
  logic                found_f;
  logic [COUNT_W-1:0]  count_f;

  // result fields
  assign res_f    = m_axis_tdata[RES_LSB +: VALUE_W];
  assign status_f = m_axis_tdata[STATUS_LSB +: STATUS_W];
  assign found_f  = m_axis_tdata[FOUND_LSB];
  assign count_f  = m_axis_tdata[COUNT_LSB +: COUNT_W];

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable({s_axis_tuser, s_axis_tdata}))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // fill count never exceeds the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count_f <= COUNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // a hit only comes with an ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && found_f |-> status_f == ST_OK)
    else $error("found with error status");

  // a taken value only comes with an ok status and no hit flag
  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_f != '0) |-> (status_f == ST_OK) && !found_f)
    else $error("value returned on failed request");

endmodule

bind value_queue_search_remove vqsr_checker u_vqsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
